FILE: src/lot_pkg.sv
// lot_pkg: payload structs, register indexes, mode codes and the back state
// enum for the lane offset trajectory unit. No dependencies.
package lot_pkg;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [1:0]         mode;
    logic               first_point;
    logic               last_point;
  } lot_in_t;

  typedef struct packed {
    logic signed [31:0] traj_x;
    logic signed [31:0] traj_y;
    logic               point_valid;
    logic               too_short;
    logic               last_in_lane;
  } lot_out_t;

  localparam logic [2:0] REG_ROT    = 3'd0;
  localparam logic [2:0] REG_TRANS  = 3'd1;
  localparam logic [2:0] REG_MINLEN = 3'd2;
  localparam logic [2:0] REG_CENTRE = 3'd3;
  localparam logic [2:0] REG_RIGHT  = 3'd4;
  localparam logic [2:0] REG_LEFT   = 3'd5;

  localparam logic [1:0] MODE_CENTRE = 2'd0;
  localparam logic [1:0] MODE_RIGHT  = 2'd1;
  localparam logic [1:0] MODE_LEFT   = 2'd2;

  typedef enum logic [3:0] {
    BK_IDLE, BK_DIFF, BK_SCALE, BK_SQA, BK_SQB, BK_SQRT, BK_DECIDE,
    BK_MULX, BK_DIVX, BK_MULY, BK_DIVY, BK_SUM, BK_OUT
  } bk_state_e;

  // Classified request passed from front to back
  typedef struct packed {
    logic signed [47:0] cx;
    logic signed [47:0] cy;
    logic signed [47:0] px;
    logic signed [47:0] py;
    logic               seg;
    logic               last;
    logic signed [31:0] off;
  } lot_job_t;

endpackage

FILE: src/lot_front.sv
// lot_front: maps raw points into car coordinates and pairs them with the
// stored previous point. Uses lot_pkg.
module lot_front import lot_pkg::*; #(
  parameter int CW = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  lot_in_t     data_i,
  input  logic [63:0] rot_i,
  input  logic [63:0] trans_i,
  input  logic [31:0] off_c_i,
  input  logic [31:0] off_r_i,
  input  logic [31:0] off_l_i,
  output logic        job_valid_o,
  input  logic        job_stall_i,
  output lot_job_t    job_o
);
  // two-step: capture products, then finish
  logic               busy_q, busy_d;
  logic signed [48:0] acx_q, acy_q;
  lot_in_t            in_q;
  logic signed [CW-1:0] prx_q, pry_q;
  logic               pres_q;
  logic               jv_q;
  lot_job_t           job_q;

  logic signed [48:0] accx, accy;
  logic signed [47:0] mx, my;
  logic signed [CW-1:0] cxs, cys;
  logic signed [31:0] offs;

  function automatic logic signed [CW-1:0] satc(input logic signed [47:0] v);
    logic signed [47:0] hi, lo;
    hi = 48'sd1 <<< (CW-1);
    hi = hi - 48'sd1;
    lo = -hi - 48'sd1;
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  assign stall_o = busy_q || jv_q;
  // two full-scale products can reach 2^47, hence 49 bits
  assign accx = 49'($signed(rot_i[63:48]) * $signed(data_i.point_x))
              + 49'($signed(rot_i[47:32]) * $signed(data_i.point_y)) + 49'sd8192;
  assign accy = 49'($signed(rot_i[31:16]) * $signed(data_i.point_x))
              + 49'($signed(rot_i[15:0]) * $signed(data_i.point_y)) + 49'sd8192;
  assign mx = 48'(acx_q >>> 14) + 48'($signed(trans_i[63:32]));
  assign my = 48'(acy_q >>> 14) + 48'($signed(trans_i[31:0]));
  assign cxs = satc(mx);
  assign cys = satc(my);

  always_comb begin
    case (in_q.mode)
      MODE_CENTRE: offs = off_c_i;
      MODE_RIGHT:  offs = off_r_i;
      MODE_LEFT:   offs = off_l_i;
      default:     offs = '0;
    endcase
  end

  assign busy_d = busy_q ? 1'b0 : (valid_i && !stall_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pres_q <= 1'b0;
      jv_q   <= 1'b0;
      prx_q  <= '0;
      pry_q  <= '0;
    end else begin
      busy_q <= busy_d;
      if (jv_q && !job_stall_i) jv_q <= 1'b0;
      if (busy_q) begin
        jv_q  <= 1'b1;
        prx_q <= cxs;
        pry_q <= cys;
        pres_q <= !in_q.last_point;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      in_q  <= data_i;
      acx_q <= accx;
      acy_q <= accy;
    end
    if (busy_q) begin
      job_q.cx   <= 48'(cxs);
      job_q.cy   <= 48'(cys);
      job_q.px   <= 48'(prx_q);
      job_q.py   <= 48'(pry_q);
      job_q.seg  <= pres_q && !in_q.first_point;
      job_q.last <= in_q.last_point;
      job_q.off  <= offs;
    end
  end

  assign job_valid_o = jv_q;
  assign job_o = job_q;
endmodule

FILE: src/lot_queue.sv
// lot_queue: two-entry queue between front and back. Uses lot_pkg.
module lot_queue import lot_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  lot_job_t data_i,
  output logic     valid_o,
  input  logic     stall_i,
  output lot_job_t data_o
);
  lot_job_t  mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;
  logic      push, pop;

  assign stall_o = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];
  assign push = valid_i && !stall_o;
  assign pop  = valid_o && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end
endmodule

FILE: src/lot_back.sv
// lot_back: length by bit-serial square root, normal offset by restoring
// divides, midpoint and saturation. Uses lot_pkg.
module lot_back import lot_pkg::*; #(
  parameter int CW = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  lot_job_t    job_i,
  input  logic [30:0] minlen_i,
  output logic        valid_o,
  input  logic        stall_i,
  output lot_out_t    data_o
);
  localparam int OW = (CW < 32) ? CW : 32;

  bk_state_e st_q, st_d;
  lot_job_t  job_q;
  logic signed [48:0] dx_q, dy_q;
  logic [48:0] a_q, b_q;
  logic [5:0]  k_q;
  logic [63:0] s_q, r_q, bit_q;
  logic [63:0] prod_q, quo_q, rem_q, ox_q;
  logic [6:0]  cnt_q;
  logic        ov_q;
  lot_out_t    out_q;
  lot_out_t    res_q;

  logic [48:0] ax, ay, m;
  logic [63:0] len, sub;
  logic [64:0] rem2;
  logic [31:0] aoff;
  logic signed [49:0] rx, ry;

  assign ax = dx_q[48] ? 49'(-dx_q) : 49'(dx_q);
  assign ay = dy_q[48] ? 49'(-dy_q) : 49'(dy_q);
  assign m  = ax > ay ? ax : ay;
  assign len = r_q << k_q;
  assign aoff = job_q.off[31] ? 32'(-job_q.off) : job_q.off;
  assign sub = r_q + bit_q;
  assign rem2 = {rem_q, prod_q[63]};

  function automatic logic signed [31:0] sato(input logic signed [49:0] v);
    logic signed [49:0] hi, lo;
    hi = (50'sd1 <<< (OW-1)) - 50'sd1;
    lo = -hi - 50'sd1;
    if (v > hi) return 32'(hi);
    if (v < lo) return 32'(lo);
    return 32'(v);
  endfunction

  logic signed [49:0] midx, midy, sox, soy;
  logic negx, negy;
  assign midx = ((50'(job_q.px) + 50'(job_q.cx)) >>> 1);
  assign midy = ((50'(job_q.py) + 50'(job_q.cy)) >>> 1);
  assign negx = (dy_q > 0) != job_q.off[31] && dy_q != 0;
  assign negy = (dx_q < 0) != job_q.off[31] && dx_q != 0;
  assign sox = negx ? -50'(ox_q) : 50'(ox_q);
  assign soy = negy ? -50'(quo_q) : 50'(quo_q);
  assign rx = midx + sox;
  assign ry = midy + soy;

  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE:   if (valid_i) st_d = job_i.seg ? BK_DIFF : BK_OUT;
      BK_DIFF:   st_d = BK_SCALE;
      BK_SCALE:  if ((m >> k_q) < 49'h80000000) st_d = BK_SQA;
      BK_SQA:    st_d = BK_SQB;
      BK_SQB:    st_d = BK_SQRT;
      BK_SQRT:   if (cnt_q == 7'd0) st_d = BK_DECIDE;
      BK_DECIDE: st_d = (r_q == 0 || len < 64'(minlen_i)) ? BK_OUT : BK_MULX;
      BK_MULX:   st_d = BK_DIVX;
      BK_DIVX:   if (cnt_q == 7'd0) st_d = BK_MULY;
      BK_MULY:   st_d = BK_DIVY;
      BK_DIVY:   if (cnt_q == 7'd0) st_d = BK_SUM;
      BK_SUM:    st_d = BK_OUT;
      BK_OUT:    if (!ov_q) st_d = BK_IDLE;
      default:   st_d = BK_IDLE;
    endcase
  end

  assign stall_o = st_q != BK_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ov_q && !stall_i) ov_q <= 1'b0;
      if (st_q == BK_OUT && !ov_q) ov_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      BK_IDLE: begin
        job_q <= job_i;
        out_q.traj_x <= '0; out_q.traj_y <= '0;
        out_q.point_valid <= 1'b0; out_q.too_short <= 1'b0;
        out_q.last_in_lane <= job_i.last;
      end
      BK_DIFF: begin
        dx_q <= 49'(job_q.cx) - 49'(job_q.px);
        dy_q <= 49'(job_q.cy) - 49'(job_q.py);
        k_q <= '0;
      end
      BK_SCALE: begin
        if ((m >> k_q) >= 49'h80000000) k_q <= k_q + 6'd1;
        else begin a_q <= ax >> k_q; b_q <= ay >> k_q; end
      end
      BK_SQA: s_q <= 64'(a_q[31:0]) * 64'(a_q[31:0]);
      BK_SQB: begin
        s_q <= s_q + 64'(b_q[31:0]) * 64'(b_q[31:0]);
        r_q <= '0; bit_q <= 64'd1 << 62; cnt_q <= 7'd31;
      end
      BK_SQRT: begin
        if (s_q >= sub) begin s_q <= s_q - sub; r_q <= (r_q >> 1) + bit_q; end
        else r_q <= r_q >> 1;
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q - 7'd1;
      end
      BK_DECIDE: if (r_q == 0 || len < 64'(minlen_i)) out_q.too_short <= 1'b1;
      BK_MULX, BK_MULY: begin
        prod_q <= 64'((st_q == BK_MULX ? b_q[31:0] : a_q[31:0])) * 64'(aoff);
        rem_q <= '0; quo_q <= '0; cnt_q <= 7'd63;
      end
      BK_DIVX, BK_DIVY: begin
        if (rem2 >= 65'(r_q)) begin
          rem_q <= 64'(rem2 - 65'(r_q)); quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= rem2[63:0]; quo_q <= {quo_q[62:0], 1'b0};
        end
        prod_q <= prod_q << 1;
        cnt_q <= cnt_q - 7'd1;
        if (st_q == BK_DIVX && cnt_q == 7'd0) ox_q <= (rem2 >= 65'(r_q)) ?
          {quo_q[62:0], 1'b1} : {quo_q[62:0], 1'b0};
      end
      BK_SUM: begin
        out_q.traj_x <= sato(rx); out_q.traj_y <= sato(ry);
        out_q.point_valid <= 1'b1;
      end
      default: ;
    endcase
    // output register: holds a waiting result while the next request runs
    if (st_q == BK_OUT && !ov_q) res_q <= out_q;
  end

  assign valid_o = ov_q;
  assign data_o = res_q;
endmodule

FILE: src/lane_offset_trajectory_unit.sv
// lane_offset_trajectory_unit: top level with APB register file, front,
// queue and back. Uses lot_pkg, lot_front, lot_queue, lot_back.
//
// channel | dir | handshake               | payload
// in      | in  | in_valid_i/in_stall_o   | lot_in_t
// out     | out | out_valid_o/out_stall_i | lot_out_t
// cfg     | in  | APB, 64-bit data        | registers at 8*i
//
// The front takes a new request only once the last has gone to the queue:
// multiply, then map and pair, then hand over. With no previous point the
// back goes straight to output; else its work is set by up to 19 scaling
// steps and the 32-step square root, then two 64-step restoring divides
// unless the segment is short. Reset loads register defaults and clears the stored point.
// A waiting result sits in the output register; the back runs on into the
// next request and holds in its last state until that register is free.
// The queue lets the front run ahead.
module lane_offset_trajectory_unit import lot_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  lot_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output lot_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  logic [63:0] rot_q, trans_q;
  logic [30:0] minlen_q;
  logic [31:0] offc_q, offr_q, offl_q;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= 64'h4000_0000_0000_4000; trans_q <= '0; minlen_q <= '0;
      offc_q <= '0; offr_q <= '0; offl_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_ROT:    rot_q <= pwdata;
        REG_TRANS:  trans_q <= pwdata;
        REG_MINLEN: minlen_q <= pwdata[30:0];
        REG_CENTRE: offc_q <= pwdata[31:0];
        REG_RIGHT:  offr_q <= pwdata[31:0];
        REG_LEFT:   offl_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROT:    prdata = rot_q;
      REG_TRANS:  prdata = trans_q;
      REG_MINLEN: prdata = 64'(minlen_q);
      REG_CENTRE: prdata = 64'(offc_q);
      REG_RIGHT:  prdata = 64'(offr_q);
      REG_LEFT:   prdata = 64'(offl_q);
      default:    prdata = '0;
    endcase
  end

  logic fv, fs, bv, bs;
  lot_job_t fj, bj;

  lot_front #(.CW(COORD_WIDTH)) u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .stall_o(in_stall_o), .data_i(in_data_i),
    .rot_i(rot_q), .trans_i(trans_q), .off_c_i(offc_q), .off_r_i(offr_q),
    .off_l_i(offl_q), .job_valid_o(fv), .job_stall_i(fs), .job_o(fj)
  );

  lot_queue u_queue (
    .clk_i, .rst_ni, .valid_i(fv), .stall_o(fs), .data_i(fj),
    .valid_o(bv), .stall_i(bs), .data_o(bj)
  );

  lot_back #(.CW(COORD_WIDTH)) u_back (
    .clk_i, .rst_ni, .valid_i(bv), .stall_o(bs), .job_i(bj), .minlen_i(minlen_q),
    .valid_o(out_valid_o), .stall_i(out_stall_i), .data_o(out_data_o)
  );
endmodule

FILE: tb/tb_lane_offset_trajectory_unit.sv
// tb_lane_offset_trajectory_unit: self-checking bench for the lane offset trajectory
// unit. Drives requests and APB writes, predicts each result and compares.
// Depends on lot_pkg and lane_offset_trajectory_unit.
module tb_lane_offset_trajectory_unit;
  import lot_pkg::*;

  localparam int CW          = 32;
  localparam int CYCLE_MAX   = 2000000;
  localparam int N_RANDOM    = 1200;
  localparam int DRAIN_WAIT  = 200;
  localparam int HOLD_CYCLES = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  lot_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  lot_out_t    out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  lane_offset_trajectory_unit #(.COORD_WIDTH(CW)) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow registers and stored point for the predictor
  logic [63:0]        rot_q, trans_q;
  logic [30:0]        minlen_q;
  logic signed [31:0] off_centre_q, off_right_q, off_left_q;
  logic signed [63:0] prev_x_q, prev_y_q;
  logic               prev_ok_q;

  lot_out_t expected_q[$];
  int       n_fail = 0;
  int       cycle_cnt = 0;
  // Idle percentages per side, and the long receiver hold-off
  int       send_idle_pct = 7;
  int       recv_idle_pct = 49;
  int       phase_no = -1;
  bit       hold_off = 1'b0;

  function automatic logic signed [63:0] clamp(logic signed [63:0] v, int w);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic logic signed [63:0] map_axis(logic signed [15:0] ca,
      logic signed [15:0] cb, logic signed [31:0] px, logic signed [31:0] py,
      logic signed [31:0] t);
    logic signed [63:0] acc;
    acc = 64'(ca) * 64'(px) + 64'(cb) * 64'(py) + 64'sd8192;
    return clamp((acc >>> 14) + 64'(t), CW);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] magn(logic signed [63:0] v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Works out the result of one point and advances the stored point
  function automatic lot_out_t trajectory_point(lot_in_t req);
    lot_out_t           res;
    logic signed [63:0] cx, cy, dx, dy, ox, oy, offv;
    logic [63:0]        ax, ay, mx, a, b, l, aoff;
    int                 k;
    cx = map_axis(rot_q[63:48], rot_q[47:32], req.point_x, req.point_y, trans_q[63:32]);
    cy = map_axis(rot_q[31:16], rot_q[15:0], req.point_x, req.point_y, trans_q[31:0]);
    res = '0;
    res.last_in_lane = req.last_point;
    if (prev_ok_q && !req.first_point) begin
      dx = cx - prev_x_q;
      dy = cy - prev_y_q;
      ax = magn(dx);
      ay = magn(dy);
      mx = (ax > ay) ? ax : ay;
      k = 0;
      while ((mx >> k) >= (64'd1 << 31)) k++;
      a = ax >> k;
      b = ay >> k;
      l = root64(a * a + b * b);
      if (l == 0 || (l << k) < 64'(minlen_q)) begin
        res.too_short = 1'b1;
      end else begin
        case (req.mode)
          MODE_CENTRE: offv = 64'(off_centre_q);
          MODE_RIGHT:  offv = 64'(off_right_q);
          MODE_LEFT:   offv = 64'(off_left_q);
          default:     offv = 0;
        endcase
        aoff = magn(offv);
        ox = 64'(b * aoff / l);
        oy = 64'(a * aoff / l);
        if (((dy > 0) != (offv < 0)) && dy != 0) ox = -ox;
        if (((dx < 0) != (offv < 0)) && dx != 0) oy = -oy;
        res.traj_x = 32'(clamp(((prev_x_q + cx) >>> 1) + ox, 32));
        res.traj_y = 32'(clamp(((prev_y_q + cy) >>> 1) + oy, 32));
        res.point_valid = 1'b1;
      end
    end
    prev_x_q = cx;
    prev_y_q = cy;
    prev_ok_q = !req.last_point;
    return res;
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Long receiver hold-off in phase 4, timed in cycles while the sender runs on
  initial begin
    wait (phase_no == 4);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Result side: random stall, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    lot_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data_o);
        n_fail++;
      end else begin
        want = expected_q.pop_front();
        if (want.traj_x !== out_data_o.traj_x)
          $display("%0t traj_x exp %h got %h", $time, want.traj_x, out_data_o.traj_x);
        if (want.traj_y !== out_data_o.traj_y)
          $display("%0t traj_y exp %h got %h", $time, want.traj_y, out_data_o.traj_y);
        if (want.point_valid !== out_data_o.point_valid)
          $display("%0t point_valid exp %b got %b", $time, want.point_valid,
                   out_data_o.point_valid);
        if (want.too_short !== out_data_o.too_short)
          $display("%0t too_short exp %b got %b", $time, want.too_short,
                   out_data_o.too_short);
        if (want.last_in_lane !== out_data_o.last_in_lane)
          $display("%0t last_in_lane exp %b got %b", $time, want.last_in_lane,
                   out_data_o.last_in_lane);
        if (want !== out_data_o) n_fail++;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ROT:    rot_q = val;
      REG_TRANS:  trans_q = val;
      REG_MINLEN: minlen_q = val[30:0];
      REG_CENTRE: off_centre_q = val[31:0];
      REG_RIGHT:  off_right_q = val[31:0];
      REG_LEFT:   off_left_q = val[31:0];
      default: ;
    endcase
  endtask

  // One request: optional idle gap, then hold valid until accepted.
  // A given row may carry a typed-in expectation, checked against the predictor's.
  task automatic send_point(lot_in_t req, bit typed, lot_out_t typed_res);
    lot_out_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      @(posedge clk_i);
      in_valid_i <= 1'b0;
    end
    pred = trajectory_point(req);
    if (typed && typed_res !== pred) begin
      $display("%0t table row exp %h predictor %h", $time, typed_res, pred);
      n_fail++;
    end
    expected_q.insert(expected_q.size(), pred);
    @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000000)) - 1000000) <<< 6;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(200000)) - 100000) <<< 10;
    endcase
  endfunction

  // A lane: a first point, a run of middle points, a last point
  task automatic send_lane(int n);
    lot_in_t  req;
    lot_out_t none;
    logic [1:0] md;
    logic signed [31:0] x, y;
    none = '0;
    md = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
    x = rand_coord();
    y = rand_coord();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) begin
        x = rand_coord(); y = rand_coord();
      end else begin
        x = x + 32'($signed($urandom_range(400000)) - 200000);
        y = y + 32'($signed($urandom_range(400000)) - 200000);
      end
      req.point_x = x;
      req.point_y = y;
      req.mode = ($urandom_range(15) == 0) ? 2'($urandom_range(3)) : md;
      req.first_point = (i == 0) || ($urandom_range(30) == 0);
      req.last_point = (i == n - 1) || ($urandom_range(30) == 0);
      send_point(req, 1'b0, none);
    end
  endtask

  typedef struct {
    lot_in_t  req;
    bit       typed;
    lot_out_t res;
  } stim_row_t;

  stim_row_t directed_tbl[$];

  function automatic stim_row_t row(logic [31:0] x, logic [31:0] y, logic [1:0] m,
      bit f, bit l, bit typed, lot_out_t r);
    stim_row_t s;
    s.req = '{point_x: x, point_y: y, mode: m, first_point: f, last_point: l};
    s.typed = typed;
    s.res = r;
    return s;
  endfunction

  initial begin
    lot_out_t z;
    z = '0;
    rot_q = 64'h4000_0000_0000_4000;
    trans_q = '0; minlen_q = '0;
    off_centre_q = '0; off_right_q = '0; off_left_q = '0;
    prev_x_q = '0; prev_y_q = '0; prev_ok_q = 1'b0;

    // Directed rows with offsets (1.0, -1.0, max)
    directed_tbl.insert(directed_tbl.size(),
                        row(32'h0001_0000, 32'h0, MODE_CENTRE, 0, 0, 1, z));
    directed_tbl.insert(directed_tbl.size(),
                        row(32'h0003_0000, 32'h0, MODE_CENTRE, 0, 0, 0, z));
    directed_tbl.insert(directed_tbl.size(),
                        row(32'h0003_0000, 32'h0, MODE_CENTRE, 0, 0, 1,
                            '{0, 0, 1'b0, 1'b1, 1'b0}));
    directed_tbl.insert(directed_tbl.size(),
                        row(32'h0003_0000, 32'h0004_0000, MODE_RIGHT, 0, 0, 0, z));
    directed_tbl.insert(directed_tbl.size(),
                        row(32'h0, 32'h0004_0000, MODE_LEFT, 0, 0, 0, z));
    directed_tbl.insert(directed_tbl.size(),
                        row(32'h0, 32'h0, 2'd3, 0, 1, 0, z));
    directed_tbl.insert(directed_tbl.size(),
                        row(32'h0, 32'h0, MODE_CENTRE, 0, 0, 1,
                            '{0, 0, 1'b0, 1'b0, 1'b0}));
    directed_tbl.insert(directed_tbl.size(),
                        row(32'h7fffffff, 32'h7fffffff, MODE_LEFT, 0, 0, 0, z));
    directed_tbl.insert(directed_tbl.size(),
                        row(32'h80000000, 32'h80000000, MODE_RIGHT, 0, 0, 0, z));
    directed_tbl.insert(directed_tbl.size(),
                        row(32'h7fffffff, 32'h80000000, MODE_CENTRE, 1, 0, 1,
                            '{0, 0, 1'b0, 1'b0, 1'b0}));
    directed_tbl.insert(directed_tbl.size(),
                        row(32'h80000000, 32'h7fffffff, MODE_LEFT, 0, 0, 0, z));
    directed_tbl.insert(directed_tbl.size(),
                        row(32'h0000_0001, 32'hffff_ffff, MODE_RIGHT, 0, 0, 0, z));
    directed_tbl.insert(directed_tbl.size(),
                        row(32'hffff_ffff, 32'h0000_0001, 2'd3, 0, 1, 0, z));
    directed_tbl.insert(directed_tbl.size(),
                        row(32'h1234_5678, 32'h8765_4321, MODE_LEFT, 1, 1, 1,
                            '{0, 0, 1'b0, 1'b0, 1'b1}));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with offsets and a minimum length
    reg_write(REG_CENTRE, 64'h0001_0000);
    reg_write(REG_RIGHT, 64'hffff_0000);
    reg_write(REG_LEFT, 64'h7fff_ffff);
    reg_write(REG_MINLEN, 64'h0001_0000);
    foreach (directed_tbl[i]) send_point(directed_tbl[i].req, directed_tbl[i].typed,
                                         directed_tbl[i].res);
    wait_drained();

    // Random phases over several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      phase_no = ph;
      case (ph)
        0: begin
          reg_write(REG_ROT, 64'h4000_0000_0000_4000);
          reg_write(REG_TRANS, 64'h0);
          reg_write(REG_MINLEN, 64'h0);
        end
        1: begin
          reg_write(REG_ROT, 64'h2d41_d2bf_2d41_2d41);
          reg_write(REG_TRANS, 64'h0010_0000_fff0_0000);
          reg_write(REG_MINLEN, 64'h0002_0000);
          reg_write(REG_CENTRE, 64'h8000_0000);
        end
        2: begin
          reg_write(REG_ROT, 64'h7fff_7fff_8000_8000);
          reg_write(REG_TRANS, 64'h7fff_ffff_8000_0000);
          reg_write(REG_MINLEN, 64'h7fff_ffff);
          send_idle_pct = 49; recv_idle_pct = 7;
        end
        3: begin
          reg_write(REG_ROT, {$urandom, $urandom});
          reg_write(REG_TRANS, {$urandom, $urandom});
          reg_write(REG_MINLEN, 64'($urandom_range(32'h0008_0000)));
          reg_write(REG_RIGHT, 64'($urandom));
          reg_write(REG_LEFT, 64'h8000_0000);
        end
        4: begin
          reg_write(REG_ROT, 64'h4000_0000_0000_4000);
          reg_write(REG_TRANS, 64'hffff_ffff_ffff_ffff);
          reg_write(REG_MINLEN, 64'h0000_0001);
          reg_write(REG_CENTRE, 64'h0003_8000);
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        default: begin
          reg_write(REG_ROT, 64'hc000_0000_0000_c000);
          reg_write(REG_MINLEN, 64'h0);
          reg_write(REG_LEFT, 64'hfffd_0000);
        end
      endcase
      for (int n = 0; n < N_RANDOM / 6; ) begin
        int len;
        len = $urandom_range(12, 2);
        send_lane(len);
        n += len;
      end
      wait_drained();
    end

    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
